// ----- rtl/tafta_pkg.sv -----
// ----------------------------------------------------------------------------
// Triangle apex package
// Shared widths, constants, payload and pipeline structs for the apex solver.
// ----------------------------------------------------------------------------
package tafta_pkg;

    localparam int COORD_W  = 32;
    localparam int ANGLE_W  = 32;
    localparam int STEPS    = 30;
    localparam logic [ANGLE_W-1:0] PI_Q29 = 32'd1686629713;

    localparam int DIFF_W   = COORD_W + 1;
    localparam int MAG_W    = (DIFF_W > 41) ? DIFF_W : 41;
    localparam int NORM_MSB = 39;
    localparam int VEC_W    = 44;
    localparam int ALPHA_W  = 33;
    localparam int THETA_W  = 34;
    localparam int ROT_W    = 33;
    localparam logic signed [ROT_W-1:0] ROT_START = 33'sd1073741824;
    localparam int PROD_W   = 2 * ROT_W;
    localparam int DEN_W    = PROD_W + 1;
    localparam int DMAG_W   = 64;
    localparam int NPROD_W  = DIFF_W + ROT_W;
    localparam int NUM_W    = NPROD_W + 1;
    localparam int CHUNK_W  = 32;
    localparam int PW       = NUM_W + ROT_W;
    localparam int QW       = COORD_W + 1;
    localparam int SUM_W    = COORD_W + 2;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_TRI    = 2'd1,
        ST_BAD_ANGLE = 2'd2,
        ST_DEGEN     = 2'd3
    } t_status;

    typedef struct packed {
        logic signed [COORD_W-1:0] b_x;
        logic signed [COORD_W-1:0] b_y;
        logic signed [COORD_W-1:0] c_x;
        logic signed [COORD_W-1:0] c_y;
        logic [ANGLE_W-1:0]        angle_at_b;
        logic [ANGLE_W-1:0]        angle_at_c;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] a_x;
        logic signed [COORD_W-1:0] a_y;
        t_status                   status;
    } t_out_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
        logic signed [DIFF_W-1:0]  dx;
        logic signed [DIFF_W-1:0]  dy;
        logic [ANGLE_W-1:0]        beta;
        logic [ANGLE_W-1:0]        gamma;
        t_status                   status;
    } t_side;

    typedef struct packed {
        logic signed [ROT_W-1:0] x1;
        logic signed [ROT_W-1:0] y1;
        logic signed [ROT_W-1:0] x2;
        logic signed [ROT_W-1:0] y2;
    } t_dir;

    typedef struct packed {
        logic [PW-1:0]             n;
        logic [DMAG_W-1:0]         d;
        logic                      neg;
        logic signed [COORD_W-1:0] base;
        t_status                   status;
    } t_div_in;

    typedef struct packed {
        logic signed [COORD_W-1:0] a;
        logic                      fail;
        t_status                   status;
    } t_div_out;

    function automatic logic [28:0] atan_q29(input int i);
        logic [28:0] v;
        case (i)
            0:  v = 29'd421657428;
            1:  v = 29'd248918915;
            2:  v = 29'd131521918;
            3:  v = 29'd66762579;
            4:  v = 29'd33510843;
            5:  v = 29'd16771758;
            6:  v = 29'd8387925;
            7:  v = 29'd4194219;
            8:  v = 29'd2097141;
            9:  v = 29'd1048575;
            default: v = 29'(64'd1 << (29 - i));
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/tafta_front.sv -----
// ----------------------------------------------------------------------------
// Apex front end
// Base vector, status checks, normalization and vectoring CORDIC for alpha.
// ----------------------------------------------------------------------------
module tafta_front (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  logic                                   i_valid,
    input  tafta_pkg::t_in_item                    i_item,
    output logic                                   o_valid,
    output tafta_pkg::t_side                       o_side,
    output logic signed [tafta_pkg::ALPHA_W-1:0]   o_alpha
);
    import tafta_pkg::*;

    logic                      r_a_valid, r_b_valid;
    t_side                     r_a_side, r_b_side, n_a_side;
    logic [MAG_W-1:0]          r_a_mx, r_a_my, n_a_mx, n_a_my;
    logic [MAG_W-1:0]          r_b_mx, r_b_my, n_b_mx, n_b_my;
    logic [MAG_W-1:0]          n_c_mx, n_c_my;
    logic                      r_a_yneg, r_b_yneg;

    logic                      r_vv [STEPS+1];
    t_side                     r_vs [STEPS+1];
    logic signed [VEC_W-1:0]   r_vx [STEPS+1];
    logic signed [VEC_W-1:0]   r_vy [STEPS+1];
    logic signed [ALPHA_W-1:0] r_va [STEPS+1];

    always_comb begin
        logic [ANGLE_W:0] sum;
        n_a_side.bx    = i_item.b_x;
        n_a_side.by    = i_item.b_y;
        n_a_side.dx    = DIFF_W'(i_item.c_x) - DIFF_W'(i_item.b_x);
        n_a_side.dy    = DIFF_W'(i_item.c_y) - DIFF_W'(i_item.b_y);
        n_a_side.beta  = i_item.angle_at_b;
        n_a_side.gamma = i_item.angle_at_c;
        sum = {1'b0, i_item.angle_at_b} + {1'b0, i_item.angle_at_c};
        if (i_item.angle_at_b == '0 || i_item.angle_at_b >= PI_Q29 ||
            i_item.angle_at_c == '0 || i_item.angle_at_c >= PI_Q29) begin
            n_a_side.status = ST_BAD_ANGLE;
        end else if (sum >= {1'b0, PI_Q29}) begin
            n_a_side.status = ST_NO_TRI;
        end else if (n_a_side.dx == '0 && n_a_side.dy == '0) begin
            n_a_side.status = ST_DEGEN;
        end else begin
            n_a_side.status = ST_OK;
        end
        n_a_mx = n_a_side.dx[DIFF_W-1] ? MAG_W'(-n_a_side.dx) : MAG_W'(n_a_side.dx);
        n_a_my = n_a_side.dy[DIFF_W-1] ? MAG_W'(-n_a_side.dy) : MAG_W'(n_a_side.dy);
    end

    always_comb begin
        n_b_mx = r_a_mx;
        n_b_my = r_a_my;
        for (int k = 0; k < 5; k++) begin
            if (((n_b_mx | n_b_my) >> (NORM_MSB + (16 >> k))) != '0) begin
                n_b_mx = n_b_mx >> (16 >> k);
                n_b_my = n_b_my >> (16 >> k);
            end
        end
    end

    always_comb begin
        n_c_mx = r_b_mx;
        n_c_my = r_b_my;
        for (int k = 0; k < 6; k++) begin
            if (((n_c_mx | n_c_my) >> (NORM_MSB + 1 - (32 >> k))) == '0) begin
                n_c_mx = n_c_mx << (32 >> k);
                n_c_my = n_c_my << (32 >> k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_vv[0]   <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_vv[0]   <= r_b_valid;
        end
        if (i_en) begin
            r_a_side <= n_a_side;
            r_a_mx   <= n_a_mx;
            r_a_my   <= n_a_my;
            r_a_yneg <= n_a_side.dx[DIFF_W-1] ^ n_a_side.dy[DIFF_W-1];
            r_b_side <= r_a_side;
            r_b_mx   <= n_b_mx;
            r_b_my   <= n_b_my;
            r_b_yneg <= r_a_yneg;
            r_vs[0]  <= r_b_side;
            r_vx[0]  <= $signed(VEC_W'(n_c_mx));
            r_vy[0]  <= r_b_yneg ? -$signed(VEC_W'(n_c_my)) : $signed(VEC_W'(n_c_my));
            r_va[0]  <= '0;
        end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_vec
        logic signed [VEC_W-1:0]   sx, sy;
        logic signed [ALPHA_W-1:0] at;
        assign sx = r_vx[i] >>> i;
        assign sy = r_vy[i] >>> i;
        assign at = $signed(ALPHA_W'(atan_q29(i)));
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vv[i+1] <= 1'b0;
            end else if (i_en) begin
                r_vv[i+1] <= r_vv[i];
            end
            if (i_en) begin
                r_vs[i+1] <= r_vs[i];
                if (!r_vy[i][VEC_W-1]) begin
                    r_vx[i+1] <= r_vx[i] + sy;
                    r_vy[i+1] <= r_vy[i] - sx;
                    r_va[i+1] <= r_va[i] + at;
                end else begin
                    r_vx[i+1] <= r_vx[i] - sy;
                    r_vy[i+1] <= r_vy[i] + sx;
                    r_va[i+1] <= r_va[i] - at;
                end
            end
        end
    end

    assign o_valid = r_vv[STEPS];
    assign o_side  = r_vs[STEPS];
    assign o_alpha = r_va[STEPS];

endmodule

// ----- rtl/tafta_rotate.sv -----
// ----------------------------------------------------------------------------
// Apex line directions
// Folds both line angles into a half turn and rotates them by CORDIC.
// ----------------------------------------------------------------------------
module tafta_rotate (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  logic                                   i_valid,
    input  tafta_pkg::t_side                       i_side,
    input  logic signed [tafta_pkg::ALPHA_W-1:0]   i_alpha,
    output logic                                   o_valid,
    output tafta_pkg::t_side                       o_side,
    output tafta_pkg::t_dir                        o_dir
);
    import tafta_pkg::*;

    localparam logic signed [THETA_W:0]   PI_WIDE  = $signed((THETA_W+1)'(PI_Q29));
    localparam logic signed [THETA_W-1:0] PI_THETA = $signed(THETA_W'(PI_Q29));

    function automatic logic signed [THETA_W-1:0] fold_down(input logic signed [THETA_W-1:0] t);
        return ($signed({t, 1'b0}) >= PI_WIDE) ? t - PI_THETA : t;
    endfunction

    function automatic logic signed [THETA_W-1:0] fold_up(input logic signed [THETA_W-1:0] t);
        return ($signed({t, 1'b0}) < -PI_WIDE) ? t + PI_THETA : t;
    endfunction

    logic                      r0_valid;
    t_side                     r0_side;
    logic signed [THETA_W-1:0] r0_t [2];
    logic signed [THETA_W-1:0] n0_t [2];

    logic                      r_rv [STEPS+1];
    t_side                     r_rs [STEPS+1];
    logic signed [ROT_W-1:0]   r_rx [2][STEPS+1];
    logic signed [ROT_W-1:0]   r_ry [2][STEPS+1];
    logic signed [THETA_W-1:0] r_rt [2][STEPS+1];

    always_comb begin
        n0_t[0] = THETA_W'(i_alpha) + $signed(THETA_W'(i_side.beta));
        n0_t[1] = THETA_W'(i_alpha) - $signed(THETA_W'(i_side.gamma));
        for (int l = 0; l < 2; l++) begin
            n0_t[l] = fold_down(fold_down(n0_t[l]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
            r_rv[0]  <= 1'b0;
        end else if (i_en) begin
            r0_valid <= i_valid;
            r_rv[0]  <= r0_valid;
        end
        if (i_en) begin
            r0_side <= i_side;
            r_rs[0] <= r0_side;
            for (int l = 0; l < 2; l++) begin
                r0_t[l]    <= n0_t[l];
                r_rt[l][0] <= fold_up(fold_up(r0_t[l]));
                r_rx[l][0] <= ROT_START;
                r_ry[l][0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_rot
        logic signed [THETA_W-1:0] at;
        assign at = $signed(THETA_W'(atan_q29(i)));
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rv[i+1] <= 1'b0;
            end else if (i_en) begin
                r_rv[i+1] <= r_rv[i];
            end
            if (i_en) begin
                r_rs[i+1] <= r_rs[i];
            end
        end
        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic signed [ROT_W-1:0] sx, sy;
            assign sx = r_rx[l][i] >>> i;
            assign sy = r_ry[l][i] >>> i;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (!r_rt[l][i][THETA_W-1]) begin
                        r_rx[l][i+1] <= r_rx[l][i] - sy;
                        r_ry[l][i+1] <= r_ry[l][i] + sx;
                        r_rt[l][i+1] <= r_rt[l][i] - at;
                    end else begin
                        r_rx[l][i+1] <= r_rx[l][i] + sy;
                        r_ry[l][i+1] <= r_ry[l][i] - sx;
                        r_rt[l][i+1] <= r_rt[l][i] + at;
                    end
                end
            end
        end
    end

    assign o_valid  = r_rv[STEPS];
    assign o_side   = r_rs[STEPS];
    assign o_dir.x1 = r_rx[0][STEPS];
    assign o_dir.y1 = r_ry[0][STEPS];
    assign o_dir.x2 = r_rx[1][STEPS];
    assign o_dir.y2 = r_ry[1][STEPS];

endmodule

// ----- rtl/tafta_solve.sv -----
// ----------------------------------------------------------------------------
// Apex line intersection
// Determinant, numerator and the scaled offsets fed to the dividers.
// ----------------------------------------------------------------------------
module tafta_solve (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  tafta_pkg::t_side     i_side,
    input  tafta_pkg::t_dir      i_dir,
    output logic                 o_valid,
    output tafta_pkg::t_div_in   o_div_x,
    output tafta_pkg::t_div_in   o_div_y
);
    import tafta_pkg::*;

    localparam int LO_W = CHUNK_W + 1 + ROT_W;
    localparam int HI_W = NUM_W - CHUNK_W + ROT_W;

    logic                      r0_valid, r1_valid, r2_valid, r3_valid;
    t_side                     r0_side, r1_side, r2_side;
    logic signed [PROD_W-1:0]  r0_pa, r0_pb;
    logic signed [NPROD_W-1:0] r0_na, r0_nb;
    logic                      r0_xzero;
    logic signed [ROT_W-1:0]   r0_x1, r0_y1, r1_x1, r1_y1;
    logic signed [DEN_W-1:0]   r1_den;
    logic signed [NUM_W-1:0]   r1_num;
    logic signed [LO_W-1:0]    r2_xlo, r2_ylo;
    logic signed [HI_W-1:0]    r2_xhi, r2_yhi;
    logic [DMAG_W-1:0]         r2_dmag;
    logic                      r2_dneg;
    t_div_in                   r3_x, r3_y, n3_x, n3_y;
    t_side                     n1_side;

    always_comb begin
        n1_side = r0_side;
        if (r0_side.status == ST_OK && (r0_xzero || r0_pa == r0_pb)) begin
            n1_side.status = ST_DEGEN;
        end
    end

    always_comb begin
        logic signed [PW-1:0] px, py;
        logic [PW-1:0]        mx, my;
        px = (PW'(r2_xhi) <<< CHUNK_W) + PW'(r2_xlo);
        py = (PW'(r2_yhi) <<< CHUNK_W) + PW'(r2_ylo);
        mx = px[PW-1] ? PW'(-px) : PW'(px);
        my = py[PW-1] ? PW'(-py) : PW'(py);
        n3_x.n      = mx + PW'(r2_dmag >> 1);
        n3_y.n      = my + PW'(r2_dmag >> 1);
        n3_x.d      = r2_dmag;
        n3_y.d      = r2_dmag;
        n3_x.neg    = px[PW-1] ^ r2_dneg;
        n3_y.neg    = py[PW-1] ^ r2_dneg;
        n3_x.base   = r2_side.bx;
        n3_y.base   = r2_side.by;
        n3_x.status = r2_side.status;
        n3_y.status = r2_side.status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r0_valid <= i_valid;
            r1_valid <= r0_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
        if (i_en) begin
            r0_side  <= i_side;
            r0_pa    <= i_dir.x1 * i_dir.y2;
            r0_pb    <= i_dir.y1 * i_dir.x2;
            r0_na    <= i_side.dx * i_dir.y2;
            r0_nb    <= i_side.dy * i_dir.x2;
            r0_xzero <= (i_dir.x1 == '0) || (i_dir.x2 == '0);
            r0_x1    <= i_dir.x1;
            r0_y1    <= i_dir.y1;

            r1_side  <= n1_side;
            r1_den   <= DEN_W'(r0_pa) - DEN_W'(r0_pb);
            r1_num   <= NUM_W'(r0_na) - NUM_W'(r0_nb);
            r1_x1    <= r0_x1;
            r1_y1    <= r0_y1;

            r2_side <= r1_side;
            r2_xlo  <= $signed({1'b0, r1_num[CHUNK_W-1:0]}) * r1_x1;
            r2_ylo  <= $signed({1'b0, r1_num[CHUNK_W-1:0]}) * r1_y1;
            r2_xhi  <= $signed(r1_num[NUM_W-1:CHUNK_W]) * r1_x1;
            r2_yhi  <= $signed(r1_num[NUM_W-1:CHUNK_W]) * r1_y1;
            r2_dmag <= r1_den[DEN_W-1] ? DMAG_W'(-r1_den) : DMAG_W'(r1_den);
            r2_dneg <= r1_den[DEN_W-1];

            r3_x <= n3_x;
            r3_y <= n3_y;
        end
    end

    assign o_valid = r3_valid;
    assign o_div_x = r3_x;
    assign o_div_y = r3_y;

endmodule

// ----- rtl/tafta_divide.sv -----
// ----------------------------------------------------------------------------
// Apex coordinate divider
// Restoring divider, one quotient bit per stage, with range check of the sum.
// ----------------------------------------------------------------------------
module tafta_divide (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  tafta_pkg::t_div_in   i_div,
    output logic                 o_valid,
    output tafta_pkg::t_div_out  o_res
);
    import tafta_pkg::*;

    localparam int HI_W = PW - QW;

    logic                      r_v    [QW+1];
    logic [DMAG_W-1:0]         r_r    [QW+1];
    logic [QW-1:0]             r_lo   [QW+1];
    logic [QW-1:0]             r_q    [QW+1];
    logic [DMAG_W-1:0]         r_d    [QW+1];
    logic                      r_big  [QW+1];
    logic                      r_neg  [QW+1];
    logic signed [COORD_W-1:0] r_base [QW+1];
    t_status                   r_st   [QW+1];

    logic [HI_W-1:0] hi;
    assign hi = i_div.n[PW-1:QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
        if (i_en) begin
            r_big[0]  <= hi >= HI_W'(i_div.d);
            r_r[0]    <= hi[DMAG_W-1:0];
            r_lo[0]   <= i_div.n[QW-1:0];
            r_q[0]    <= '0;
            r_d[0]    <= i_div.d;
            r_neg[0]  <= i_div.neg;
            r_base[0] <= i_div.base;
            r_st[0]   <= i_div.status;
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_div
        logic [DMAG_W:0] r2, diff;
        logic            ge;
        assign r2   = {r_r[k], r_lo[k][QW-1]};
        assign ge   = r2 >= {1'b0, r_d[k]};
        assign diff = r2 - {1'b0, r_d[k]};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
            if (i_en) begin
                r_r[k+1]    <= ge ? diff[DMAG_W-1:0] : r2[DMAG_W-1:0];
                r_q[k+1]    <= {r_q[k][QW-2:0], ge};
                r_lo[k+1]   <= r_lo[k] << 1;
                r_d[k+1]    <= r_d[k];
                r_big[k+1]  <= r_big[k];
                r_neg[k+1]  <= r_neg[k];
                r_base[k+1] <= r_base[k];
                r_st[k+1]   <= r_st[k];
            end
        end
    end

    always_comb begin
        logic signed [SUM_W-1:0] qe, a;
        qe = $signed({1'b0, r_q[QW]});
        a  = SUM_W'(r_base[QW]) + (r_neg[QW] ? -qe : qe);
        o_res.a      = a[COORD_W-1:0];
        o_res.fail   = r_big[QW] || !((a[SUM_W-1:COORD_W-1] == '0) ||
                                      (a[SUM_W-1:COORD_W-1] == '1));
        o_res.status = r_st[QW];
    end

    assign o_valid = r_v[QW];

endmodule

// ----- rtl/triangle_apex_from_two_angles_core.sv -----
// ----------------------------------------------------------------------------
// Triangle apex from two base angles
// Angle-side-angle triangulation of apex A from base points B, C and angles.
// ----------------------------------------------------------------------------
// Input channel i_in_valid / o_in_ready carries one t_in_item per
// transaction: base points B and C in Q16.16 and the interior angles at B
// and C in unsigned Q3.29 radians. Output channel o_out_valid / i_out_ready
// returns one t_out_item per input transaction, in order: apex A and a
// status (ok, no triangle, invalid angle or degenerate, which also covers an
// overflow). A is zero whenever status is not ok.
// One transaction can be accepted every cycle unless the output is stalled;
// that figure is set by the fully pipelined datapath, where the two 30-stage
// CORDIC chains and the 33-stage restoring dividers each retire one item
// per cycle.
// A stall of i_out_ready freezes the whole pipeline while the result is held,
// and o_in_ready drops only while a result is waiting to be taken.
// Synchronous reset clears every valid bit; the data path needs no clearing.
// ----------------------------------------------------------------------------
module triangle_apex_from_two_angles_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  tafta_pkg::t_in_item   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output tafta_pkg::t_out_item  o_out_data
);
    import tafta_pkg::*;

    logic                      en;
    logic                      f_valid, r_valid, s_valid, dx_valid, dy_valid;
    t_side                     f_side, r_side;
    logic signed [ALPHA_W-1:0] f_alpha;
    t_dir                      r_dir;
    t_div_in                   s_x, s_y;
    t_div_out                  d_x, d_y;
    logic                      r_out_valid;
    t_out_item                 r_out, n_out;

    assign en = !r_out_valid || i_out_ready;

    tafta_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(i_in_valid), .i_item(i_in_data),
        .o_valid(f_valid), .o_side(f_side), .o_alpha(f_alpha)
    );

    tafta_rotate u_rotate (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(f_valid), .i_side(f_side), .i_alpha(f_alpha),
        .o_valid(r_valid), .o_side(r_side), .o_dir(r_dir)
    );

    tafta_solve u_solve (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(r_valid), .i_side(r_side), .i_dir(r_dir),
        .o_valid(s_valid), .o_div_x(s_x), .o_div_y(s_y)
    );

    tafta_divide u_div_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(s_valid), .i_div(s_x),
        .o_valid(dx_valid), .o_res(d_x)
    );

    tafta_divide u_div_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(s_valid), .i_div(s_y),
        .o_valid(dy_valid), .o_res(d_y)
    );

    always_comb begin
        n_out.status = d_x.status;
        if (d_x.status == ST_OK && (d_x.fail || d_y.fail)) begin
            n_out.status = ST_DEGEN;
        end
        n_out.a_x = (n_out.status == ST_OK) ? d_x.a : '0;
        n_out.a_y = (n_out.status == ST_OK) ? d_y.a : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= dx_valid && dy_valid;
        end
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_in_ready  = en;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- rtl/tafta_checker.sv -----
// ----------------------------------------------------------------------------
// Apex port checker
// Concurrent checks on the ports of the apex core, bound to the top level.
// ----------------------------------------------------------------------------
module tafta_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input tafta_pkg::t_in_item   i_in_data,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input tafta_pkg::t_out_item  o_out_data
);
    import tafta_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output transaction changed while stalled");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready == (!o_out_valid || i_out_ready))
        else $error("input ready does not follow output stall");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_OK |->
            o_out_data.a_x == '0 && o_out_data.a_y == '0)
        else $error("apex not cleared on failing status");

    a_reset: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind triangle_apex_from_two_angles_core tafta_checker u_tafta_checker (.*);
